FILE: rtl/core/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Types and constants shared by the coordinate cache, its cells and checker.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned OccW    = 7;

  localparam logic [CfgW-1:0] CfgReset = 7'd64;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } op_e;

  // What every cell of the row does with the current beat.
  typedef enum logic [1:0] {
    ACT_HOLD    = 2'd0,
    ACT_PROMOTE = 2'd1,
    ACT_PUSH    = 2'd2,
    ACT_PULL    = 2'd3
  } act_e;

  typedef struct packed {
    act_e act;
    logic evict;
  } cell_ctl_t;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_z;
    logic [HandleW-1:0]       entry_data;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic [HandleW-1:0]       data_out;
    logic                     evicted;
    logic signed [CoordW-1:0] evicted_x;
    logic signed [CoordW-1:0] evicted_z;
    logic [OccW-1:0]          occupancy;
  } rsp_t;

endpackage

FILE: rtl/core/lcc_cell.sv
// ----------------------------------------------------------------------------
// lcc_cell
// One entry of the recency-ordered row: compares its key, forwards the
// search results along the row and shifts entries to or from its neighbors.
// ----------------------------------------------------------------------------
module lcc_cell #(
  parameter int unsigned KeyW  = 16,
  parameter int unsigned DataW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcc_pkg::cell_ctl_t ctl_i,
  input  logic [KeyW-1:0]   key_x_i,
  input  logic [KeyW-1:0]   key_z_i,
  input  logic [KeyW-1:0]   prev_x_i,
  input  logic [KeyW-1:0]   prev_z_i,
  input  logic [DataW-1:0]  prev_data_i,
  input  logic              prev_valid_i,
  input  logic [KeyW-1:0]   next_x_i,
  input  logic [KeyW-1:0]   next_z_i,
  input  logic [DataW-1:0]  next_data_i,
  input  logic              next_valid_i,
  input  logic              hb_i,
  output logic              hb_o,
  input  logic              ha_i,
  output logic              ha_o,
  input  logic [DataW-1:0]  sel_data_i,
  output logic [DataW-1:0]  sel_data_o,
  input  logic [KeyW-1:0]   ev_x_i,
  output logic [KeyW-1:0]   ev_x_o,
  input  logic [KeyW-1:0]   ev_z_i,
  output logic [KeyW-1:0]   ev_z_o,
  output logic [KeyW-1:0]   key_x_o,
  output logic [KeyW-1:0]   key_z_o,
  output logic [DataW-1:0]  data_o,
  output logic              valid_o
);
  import lcc_pkg::*;

  logic [KeyW-1:0]  key_x_q, key_x_d;
  logic [KeyW-1:0]  key_z_q, key_z_d;
  logic [DataW-1:0] data_q, data_d;
  logic             valid_q, valid_d;
  logic             match;
  logic             last;

  assign match = valid_q && (key_x_q == key_x_i) && (key_z_q == key_z_i);
  // Tail of the occupied run: next cell is empty.
  assign last  = valid_q && !next_valid_i;

  assign hb_o       = hb_i | match;
  assign ha_o       = ha_i | match;
  assign sel_data_o = sel_data_i | (match ? data_q : '0);
  assign ev_x_o     = ev_x_i | (last ? key_x_q : '0);
  assign ev_z_o     = ev_z_i | (last ? key_z_q : '0);

  always_comb begin
    key_x_d = key_x_q;
    key_z_d = key_z_q;
    data_d  = data_q;
    valid_d = valid_q;
    unique case (ctl_i.act)
      ACT_HOLD: begin
      end
      ACT_PROMOTE: begin
        // Cells up to the hit slide back by one.
        if (ha_o) begin
          key_x_d = prev_x_i;
          key_z_d = prev_z_i;
          data_d  = prev_data_i;
        end
      end
      ACT_PUSH: begin
        key_x_d = prev_x_i;
        key_z_d = prev_z_i;
        data_d  = prev_data_i;
        // On eviction the old tail does not move past its slot.
        valid_d = prev_valid_i && (valid_q || !ctl_i.evict);
      end
      ACT_PULL: begin
        // Close the gap left by the removed entry.
        if (hb_o) begin
          key_x_d = next_x_i;
          key_z_d = next_z_i;
          data_d  = next_data_i;
          valid_d = next_valid_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_x_q <= key_x_d;
    key_z_q <= key_z_d;
    data_q  <= data_d;
  end

  assign key_x_o = key_x_q;
  assign key_z_o = key_z_q;
  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

FILE: rtl/core/lru_coordinate_cache.sv
// ----------------------------------------------------------------------------
// lru_coordinate_cache
// Fully associative cache keyed by an (x,z) coordinate pair, LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries one
//   operation per beat: lookup, insert or remove. Response channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one beat per
//   request, in order. cfg_we_i writes the entry limit from cfg_wdata_i;
//   write it only while no request is in flight.
//   Entries live in a row of cells ordered by recency, cell 0 most recent.
//   Each cycle every cell compares its key, and the row shifts by one to
//   promote, insert or close a gap.
//   The response is registered at the edge that takes the request.
//   Throughput is one request per cycle while the response is not
//   stalled, set by the combinational search and shift across the cell row.
//   While the response register holds a beat that the receiver stalls,
//   in_stall_o is raised; a stalled beat is held unchanged.
//   Reset clears all cell valid bits and the entry count and restores the
//   limit to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_coordinate_cache #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DATA_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lcc_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lcc_pkg::rsp_t out_data_o
);
  import lcc_pkg::*;

  localparam int unsigned KeyW  = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam int unsigned DataW = (DATA_BITS < HandleW) ? DATA_BITS : HandleW;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned OutCW = (CntW < OccW) ? CntW : OccW;

  logic [CfgW-1:0] cfg_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic            accept;
  logic [CmpW-1:0] cfg_ext, lim;
  logic            full;
  logic            hit;
  logic            ins_miss;
  cell_ctl_t       ctl;

  logic [KeyW-1:0]  srch_x, srch_z;
  logic [KeyW-1:0]  ent_x    [CAPACITY+2];
  logic [KeyW-1:0]  ent_z    [CAPACITY+2];
  logic [DataW-1:0] ent_data [CAPACITY+2];
  logic             ent_vld  [CAPACITY+2];
  logic             hb       [CAPACITY+1];
  logic             ha       [CAPACITY+1];
  logic [DataW-1:0] sel      [CAPACITY+1];
  logic [KeyW-1:0]  evx      [CAPACITY+1];
  logic [KeyW-1:0]  evz      [CAPACITY+1];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign srch_x = in_data_i.coord_x[KeyW-1:0];
  assign srch_z = in_data_i.coord_z[KeyW-1:0];

  // Effective limit: zero acts as one, clamp to the row length.
  always_comb begin
    cfg_ext = CmpW'(cfg_q);
    if (cfg_ext == '0) begin
      lim = CmpW'(1);
    end else if (cfg_ext > CmpW'(CAPACITY)) begin
      lim = CmpW'(CAPACITY);
    end else begin
      lim = cfg_ext;
    end
  end

  assign full     = CmpW'(cnt_q) >= lim;
  assign hit      = hb[CAPACITY];
  assign ins_miss = (in_data_i.op == OP_INSERT) && !hit;

  always_comb begin
    ctl.act   = ACT_HOLD;
    ctl.evict = ins_miss && full;
    if (accept) begin
      unique case (in_data_i.op)
        OP_LOOKUP: ctl.act = ACT_PROMOTE;
        OP_INSERT: ctl.act = hit ? ACT_PROMOTE : ACT_PUSH;
        OP_REMOVE: ctl.act = ACT_PULL;
        OP_RSVD:   ctl.act = ACT_HOLD;
        default:   ctl.act = ACT_HOLD;
      endcase
    end
  end

  // Head of the row feeds cell 0; the tail past the last cell is empty.
  assign ent_x[0]             = srch_x;
  assign ent_z[0]             = srch_z;
  assign ent_data[0]          = ins_miss ? in_data_i.entry_data[DataW-1:0]
                                         : sel[CAPACITY];
  assign ent_vld[0]           = 1'b1;
  assign ent_x[CAPACITY+1]    = '0;
  assign ent_z[CAPACITY+1]    = '0;
  assign ent_data[CAPACITY+1] = '0;
  assign ent_vld[CAPACITY+1]  = 1'b0;

  assign hb[0]        = 1'b0;
  assign ha[CAPACITY] = 1'b0;
  assign sel[0]       = '0;
  assign evx[0]       = '0;
  assign evz[0]       = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lcc_cell #(
      .KeyW  (KeyW),
      .DataW (DataW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .key_x_i     (srch_x),
      .key_z_i     (srch_z),
      .prev_x_i    (ent_x[i]),
      .prev_z_i    (ent_z[i]),
      .prev_data_i (ent_data[i]),
      .prev_valid_i(ent_vld[i]),
      .next_x_i    (ent_x[i+2]),
      .next_z_i    (ent_z[i+2]),
      .next_data_i (ent_data[i+2]),
      .next_valid_i(ent_vld[i+2]),
      .hb_i        (hb[i]),
      .hb_o        (hb[i+1]),
      .ha_i        (ha[i+1]),
      .ha_o        (ha[i]),
      .sel_data_i  (sel[i]),
      .sel_data_o  (sel[i+1]),
      .ev_x_i      (evx[i]),
      .ev_x_o      (evx[i+1]),
      .ev_z_i      (evz[i]),
      .ev_z_o      (evz[i+1]),
      .key_x_o     (ent_x[i+1]),
      .key_z_o     (ent_z[i+1]),
      .data_o      (ent_data[i+1]),
      .valid_o     (ent_vld[i+1])
    );
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (ins_miss && !full) begin
        cnt_d = cnt_q + CntW'(1);
      end else if ((in_data_i.op == OP_REMOVE) && hit) begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_comb begin
    rsp_d           = '0;
    rsp_d.hit       = (in_data_i.op != OP_RSVD) && hit;
    if ((in_data_i.op == OP_LOOKUP) && hit) begin
      rsp_d.data_out[DataW-1:0] = sel[CAPACITY];
    end
    rsp_d.evicted   = ctl.evict;
    if (ctl.evict) begin
      rsp_d.evicted_x[KeyW-1:0] = evx[CAPACITY];
      rsp_d.evicted_z[KeyW-1:0] = evz[CAPACITY];
    end
    rsp_d.occupancy[OutCW-1:0] = cnt_d[OutCW-1:0];
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the response while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

FILE: rtl/core/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks for the coordinate cache, bound to the top level.
// ----------------------------------------------------------------------------
module lcc_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lcc_pkg::rsp_t out_data_o
);
  import lcc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response beat changed");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while response stalled");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.evicted |-> !out_data_o.hit &&
      out_data_o.occupancy != '0)
    else $error("eviction reported on hit or empty cache");

  a_data_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.data_out != '0) |-> out_data_o.hit &&
      !out_data_o.evicted)
    else $error("data returned without a hit");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 127) || (out_data_o.occupancy <= CAPACITY))
    else $error("occupancy above capacity");

endmodule

bind lru_coordinate_cache lcc_checker #(
  .CAPACITY(CAPACITY)
) u_lcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/lru_coordinate_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_coordinate_cache_tb
// Drives lookup, insert, remove and reserved beats into the coordinate cache.
// A behavioral LRU model predicts each response, or a directed row gives it,
// and the predictions are matched in order against the response channel. A
// short directed table comes first. Random phases follow, each with its own
// entry limit, key pool and idle pattern.
// ----------------------------------------------------------------------------
module lru_coordinate_cache_tb;
  import lcc_pkg::*;

  localparam int unsigned Slots       = 64;
  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseBeats  = 150;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [CfgW-1:0] limit;
    req_t            req;
    logic            typed;
    rsp_t            want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [6:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_data_o;

  // Behavioral copy of the cache contents and the limit register.
  logic signed [CoordW-1:0] ent_x      [Slots];
  logic signed [CoordW-1:0] ent_z      [Slots];
  logic [HandleW-1:0]       ent_handle [Slots];
  bit                       ent_valid  [Slots];
  int                       ent_rank   [Slots];
  int                       ent_count = 0;
  int                       entry_limit = int'(CfgReset);

  rsp_t pending_rsp_q [$];
  int   errors = 0;
  int   quiet_cycles = 0;

  int rx_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic signed [CoordW-1:0] pool_x [128];
  logic signed [CoordW-1:0] pool_z [128];

  int phase_limit [NumPhases] = '{64, 1, 0, 127, 7, 64, 40};
  int phase_pool  [NumPhases] = '{96, 8, 4, 120, 20, 80, 50};

  dir_row_t dir_tab [24] = '{
    '{ROW_BEAT, 7'd0, '{OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_BEAT, 7'd0, '{OP_REMOVE, 16'h0005, 16'h0005, 16'h0000}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_BEAT, 7'd0, '{OP_RSVD, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd0}},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h8000, 16'h7FFF, 16'hFFFF}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_BEAT, 7'd0, '{OP_LOOKUP, 16'h8000, 16'h7FFF, 16'h0000}, 1'b1,
      '{1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h8000, 16'h7FFF, 16'h1234}, 1'b1,
      '{1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_BEAT, 7'd0, '{OP_LOOKUP, 16'h8000, 16'h7FFF, 16'h0000}, 1'b1,
      '{1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd2}},
    '{ROW_BEAT, 7'd0, '{OP_RSVD, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1,
      '{1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd2}},
    // limit of zero behaves as one: the next new key evicts the oldest entry
    '{ROW_LIMIT, 7'd0, '0, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h0001, 16'h0002, 16'h00AA}, 1'b1,
      '{1'b0, 16'h0000, 1'b1, 16'h8000, 16'h7FFF, 7'd2}},
    '{ROW_BEAT, 7'd0, '{OP_REMOVE, 16'h7FFF, 16'h8000, 16'h0000}, 1'b1,
      '{1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 7'd1}},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h0003, 16'h0004, 16'h5555}, 1'b0, '0},
    '{ROW_LIMIT, 7'd127, '0, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h0001}, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h8000, 16'h8000, 16'hAAAA}, 1'b0, '0},
    '{ROW_LIMIT, 7'd2, '0, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h7FFF, 16'h7FFF, 16'h7777}, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_LOOKUP, 16'h0003, 16'h0004, 16'h0000}, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b0, '0},
    '{ROW_LIMIT, 7'd64, '0, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_REMOVE, 16'h7FFF, 16'h7FFF, 16'h0000}, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_REMOVE, 16'h0001, 16'h0002, 16'h0000}, 1'b0, '0},
    '{ROW_BEAT, 7'd0, '{OP_INSERT, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0}
  };

  lru_coordinate_cache DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Append a predicted response beat at the tail of the queue.
  function automatic void exp_put(rsp_t v);
    pending_rsp_q.insert(pending_rsp_q.size(), v);
  endfunction

  // Take the oldest predicted response beat off the queue.
  function automatic rsp_t exp_take();
    rsp_t v;
    v = pending_rsp_q[0];
    pending_rsp_q.delete(0);
    return v;
  endfunction

  function automatic int first_free();
    int i;
    for (i = 0; i < Slots; i++) begin
      if (!ent_valid[i]) return i;
    end
    return -1;
  endfunction

  function automatic void make_newest(int slot);
    int i;
    int r;
    r = ent_rank[slot];
    for (i = 0; i < Slots; i++) begin
      if (ent_valid[i] && ent_rank[i] < r) ent_rank[i]++;
    end
    ent_rank[slot] = 0;
  endfunction

  function automatic void retire(int slot);
    int i;
    int r;
    r = ent_rank[slot];
    ent_valid[slot] = 1'b0;
    for (i = 0; i < Slots; i++) begin
      if (ent_valid[i] && ent_rank[i] > r) ent_rank[i]--;
    end
    if (ent_count > 0) ent_count--;
  endfunction

  // Apply one beat to the model cache and return the response it produces.
  function automatic rsp_t cache_access(req_t r);
    rsp_t res;
    int   lim;
    int   slot;
    int   old;
    int   i;
    res = '0;
    lim = entry_limit;
    if (lim == 0) lim = 1;
    if (lim > Slots) lim = Slots;
    if (r.op != OP_RSVD) begin
      slot = -1;
      for (i = 0; i < Slots; i++) begin
        if (slot < 0 && ent_valid[i] && ent_x[i] == r.coord_x && ent_z[i] == r.coord_z)
          slot = i;
      end
      res.hit = (slot >= 0);
      case (r.op)
        OP_LOOKUP: begin
          if (slot >= 0) begin
            res.data_out = ent_handle[slot];
            make_newest(slot);
          end
        end
        OP_INSERT: begin
          if (slot >= 0) begin
            make_newest(slot);
          end else begin
            if (ent_count >= lim || first_free() < 0) begin
              old = -1;
              for (i = 0; i < Slots; i++) begin
                if (ent_valid[i] && (old < 0 || ent_rank[i] > ent_rank[old])) old = i;
              end
              if (old >= 0) begin
                res.evicted   = 1'b1;
                res.evicted_x = ent_x[old];
                res.evicted_z = ent_z[old];
                retire(old);
              end
            end
            slot = first_free();
            if (slot >= 0) begin
              for (i = 0; i < Slots; i++) begin
                if (ent_valid[i]) ent_rank[i]++;
              end
              ent_x[slot]      = r.coord_x;
              ent_z[slot]      = r.coord_z;
              ent_handle[slot] = r.entry_data;
              ent_valid[slot]  = 1'b1;
              ent_rank[slot]   = 0;
              ent_count++;
            end
          end
        end
        OP_REMOVE: begin
          if (slot >= 0) retire(slot);
        end
        default: ;
      endcase
    end
    res.occupancy = ent_count[OccW-1:0];
    return res;
  endfunction

  // Idle for a random gap, then hold the beat until it is taken.
  task automatic send_beat(input req_t r, input int gap_pct, input bit typed, input rsp_t want);
    rsp_t model_rsp;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_rsp = cache_access(r);
    exp_put(typed ? want : model_rsp);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    entry_limit = int'(value);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: random stall, or a long counted hold when one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Response check and watchdog.
  always @(posedge clk_i) begin
    rsp_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response beat with no request pending");
          errors++;
        end else begin
          w = exp_take();
          if (out_data_o.hit !== w.hit) begin
            $error("hit: expected %0d, got %0d", w.hit, out_data_o.hit);
            errors++;
          end
          if (out_data_o.data_out !== w.data_out) begin
            $error("data_out: expected %0h, got %0h", w.data_out, out_data_o.data_out);
            errors++;
          end
          if (out_data_o.evicted !== w.evicted) begin
            $error("evicted: expected %0d, got %0d", w.evicted, out_data_o.evicted);
            errors++;
          end
          if (out_data_o.evicted_x !== w.evicted_x) begin
            $error("evicted_x: expected %0d, got %0d", w.evicted_x, out_data_o.evicted_x);
            errors++;
          end
          if (out_data_o.evicted_z !== w.evicted_z) begin
            $error("evicted_z: expected %0d, got %0d", w.evicted_z, out_data_o.evicted_z);
            errors++;
          end
          if (out_data_o.occupancy !== w.occupancy) begin
            $error("occupancy: expected %0d, got %0d", w.occupancy, out_data_o.occupancy);
            errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("FAIL lru_coordinate_cache");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int   p;
    int   n;
    int   i;
    int   k;
    int   d;
    int   tx_gap_pct;
    req_t r;

    for (i = 0; i < Slots; i++) begin
      ent_valid[i] = 1'b0;
      ent_rank[i]  = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_LIMIT) begin
        drain();
        write_limit(dir_tab[i].limit);
      end else begin
        send_beat(dir_tab[i].req, 0, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    for (p = 0; p < NumPhases; p++) begin
      drain();
      write_limit(CfgW'(phase_limit[p]));
      // Pool keys share an x now and then so that z alone tells them apart.
      for (i = 0; i < phase_pool[p]; i++) begin
        pool_x[i] = (i > 0 && $urandom_range(0, 3) == 0) ? pool_x[i-1]
                                                         : CoordW'($urandom);
        pool_z[i] = CoordW'($urandom);
      end
      case (p % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_gap_pct = 74; rx_stall_pct <= 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct <= 74; end
        default: begin tx_gap_pct = 32; rx_stall_pct <= 32; end
      endcase
      for (n = 0; n < PhaseBeats; n++) begin
        if (p == 0 && n == 50) hold_reqs <= hold_reqs + 1;
        if (p == 2 && n == 75) drain();
        d = $urandom_range(0, 99);
        if (d < 40)      r.op = OP_INSERT;
        else if (d < 75) r.op = OP_LOOKUP;
        else if (d < 97) r.op = OP_REMOVE;
        else             r.op = OP_RSVD;
        if ($urandom_range(0, 99) < 92) begin
          k = $urandom_range(0, phase_pool[p] - 1);
          r.coord_x = pool_x[k];
          r.coord_z = pool_z[k];
        end else begin
          r.coord_x = CoordW'($urandom);
          r.coord_z = CoordW'($urandom);
        end
        r.entry_data = HandleW'($urandom);
        send_beat(r, tx_gap_pct, 1'b0, '0);
      end
    end

    rx_stall_pct <= 0;
    drain();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS lru_coordinate_cache");
    end else begin
      $display("FAIL lru_coordinate_cache");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lcc_pkg.sv
rtl/core/lcc_cell.sv
rtl/core/lru_coordinate_cache.sv
rtl/core/lcc_checker.sv
tb/lru_coordinate_cache_tb.sv
